### hdl/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and constants of the scan line segmenter.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int unsigned ANGLE_STEPS_DEF = 360;
  localparam int unsigned TRIG_FRAC_DEF   = 14;

  // ROM entries are signed and sized for the largest fraction width
  localparam int unsigned TRIG_W     = 18;
  localparam int unsigned LIMB_W     = 17;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [15:0] TOL_ONE       = 16'd16384;
  localparam int unsigned TOL_SQ_SHIFT  = 28;
  localparam logic [15:0] MIN_RANGE_RST = 16'd100;
  localparam logic [15:0] TOL_RST       = 16'd3277;
  localparam logic [15:0] CAP_RST       = 16'd6000;
  localparam logic [8:0]  SEG_MAX       = 9'd511;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    CFG_MIN_RANGE = 2'd0,
    CFG_TOL       = 2'd1,
    CFG_CAP       = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0]              rng;
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
    logic                     valid;
    logic                     scan_end;
  } lss_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CONV,
    BK_PLACE,
    BK_SPLIT,
    BK_DECIDE,
    BK_FINISH
  } back_state_e;

  typedef enum logic [3:0] {
    AD_PX,
    AD_PY,
    AD_D,
    AD_S1,
    AD_S2,
    AD_A2,
    AD_T,
    AD_R,
    AD_L
  } acc_dest_e;

  typedef struct packed {
    acc_dest_e  dst;
    logic [2:0] sh;
    logic       neg;
  } mul_op_t;

endpackage

### hdl/lidar_scan_segmenter_core.sv
// ----------------------------------------------------------------------------
// lidar_scan_segmenter_core
// Splits lidar scan lines into straight segments at direction changes.
// One shared 17x17 multiplier runs 25 partial products for point conversion
// and the exact split test. The back handles one queued sample at a time,
// while the front can take further samples into the queue.
// Reset: asynchronous, active low; control registers reset, scan cleared.
// ----------------------------------------------------------------------------
module lidar_scan_segmenter_core #(
  parameter int unsigned ANGLE_STEPS        = lss_pkg::ANGLE_STEPS_DEF,
  parameter int unsigned TRIG_FRACTION_BITS = lss_pkg::TRIG_FRAC_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        range_mm_i,
  input  logic               scan_end_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] begin_x_o,
  output logic signed [15:0] begin_y_o,
  output logic signed [15:0] end_x_o,
  output logic signed [15:0] end_y_o,
  output logic [15:0]        min_range_mm_o,
  output logic [8:0]         segment_index_o,
  output logic               segment_last_o
);
  import lss_pkg::*;

  logic [15:0] min_range_q, tol_q, cap_q;
  logic        push, full, pop, empty;
  lss_item_t   fr_item, bk_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_q <= MIN_RANGE_RST;
      tol_q       <= TOL_RST;
      cap_q       <= CAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_RANGE: min_range_q <= cfg_data_i;
        CFG_TOL:       tol_q       <= cfg_data_i;
        CFG_CAP:       cap_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lss_front #(
    .ANGLE_STEPS        (ANGLE_STEPS),
    .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .range_mm_i        (range_mm_i),
    .scan_end_i        (scan_end_i),
    .min_valid_range_i (min_range_q),
    .full_i            (full),
    .push_o            (push),
    .item_o            (fr_item)
  );

  lss_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (fr_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (bk_item),
    .empty_o (empty)
  );

  lss_back #(
    .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .item_i          (bk_item),
    .pop_o           (pop),
    .tol_i           (tol_q),
    .cap_i           (cap_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .begin_x_o       (begin_x_o),
    .begin_y_o       (begin_y_o),
    .end_x_o         (end_x_o),
    .end_y_o         (end_y_o),
    .min_range_mm_o  (min_range_mm_o),
    .segment_index_o (segment_index_o),
    .segment_last_o  (segment_last_o)
  );

endmodule

### hdl/lss_fifo.sv
// ----------------------------------------------------------------------------
// lss_fifo
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module lss_fifo #(
  parameter int unsigned DEPTH = lss_pkg::FIFO_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lss_pkg::lss_item_t item_i,
  output logic              full_o,
  input  logic              pop_i,
  output lss_pkg::lss_item_t item_o,
  output logic              empty_o
);
  import lss_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  lss_item_t     mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### hdl/lss_front.sv
// ----------------------------------------------------------------------------
// lss_front
// Input side: accepts samples, tracks the angle step, checks the range
// against the validity floor and looks up sine and cosine.
// ----------------------------------------------------------------------------
module lss_front #(
  parameter int unsigned ANGLE_STEPS        = lss_pkg::ANGLE_STEPS_DEF,
  parameter int unsigned TRIG_FRACTION_BITS = lss_pkg::TRIG_FRAC_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        range_mm_i,
  input  logic               scan_end_i,
  input  logic [15:0]        min_valid_range_i,
  input  logic               full_i,
  output logic               push_o,
  output lss_pkg::lss_item_t item_o
);
  import lss_pkg::*;

  localparam int unsigned ANGLE_W = $clog2(ANGLE_STEPS);

  // Taylor series divisors: (2k)(2k+1) for sine, (2k-1)(2k) for cosine
  localparam longint unsigned SIN_DIV [9] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                              64'd156, 64'd210, 64'd272, 64'd342};
  localparam longint unsigned COS_DIV [9] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                              64'd132, 64'd182, 64'd240, 64'd306};

  function automatic longint rom_round(longint q);
    longint r;
    r = (q < 0) ? 64'sd0 : q;
    return (r + (64'sd1 <<< (29 - TRIG_FRACTION_BITS))) >>> (30 - TRIG_FRACTION_BITS);
  endfunction

  // quarter-wave reduction plus truncating Taylor series in Q30
  function automatic logic [2*TRIG_W-1:0] trig_entry(int unsigned idx);
    longint unsigned four, quad, rem, u, u2, ts, tc;
    longint ss, cs, s, c, so, co;
    four = 64'(idx) * 64'd4;
    quad = four / ANGLE_STEPS;
    rem  = four % ANGLE_STEPS;
    u    = (rem * HALF_PI_Q30) / ANGLE_STEPS;
    u2   = (u * u) >> 30;
    ts   = u;
    tc   = 64'd1 << 30;
    ss   = $signed(u);
    cs   = $signed(tc);
    for (int k = 1; k <= 9; k++) begin
      ts = ((ts * u2) >> 30) / SIN_DIV[k-1];
      tc = ((tc * u2) >> 30) / COS_DIV[k-1];
      if ((k & 1) != 0) begin
        ss = ss - $signed(ts);
        cs = cs - $signed(tc);
      end else begin
        ss = ss + $signed(ts);
        cs = cs + $signed(tc);
      end
    end
    s = rom_round(ss);
    c = rom_round(cs);
    case (quad[1:0])
      2'd0: begin so = s;  co = c;  end
      2'd1: begin so = c;  co = -s; end
      2'd2: begin so = -s; co = -c; end
      default: begin so = -c; co = s; end
    endcase
    return {TRIG_W'(so), TRIG_W'(co)};
  endfunction

  logic [2*TRIG_W-1:0] rom_w [ANGLE_STEPS];

  for (genvar g = 0; g < ANGLE_STEPS; g++) begin : g_rom
    localparam logic [2*TRIG_W-1:0] ENTRY = trig_entry(g);
    assign rom_w[g] = ENTRY;
  end

  logic [ANGLE_W-1:0] angle_q;
  logic               stg_valid_q;
  lss_item_t          stg_q;
  logic               accept;

  assign push_o     = stg_valid_q && !full_i;
  assign in_ready_o = !stg_valid_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign item_o     = stg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q     <= '0;
      stg_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        stg_valid_q <= 1'b1;
        if (scan_end_i || angle_q == ANGLE_W'(ANGLE_STEPS - 1)) begin
          angle_q <= '0;
        end else begin
          angle_q <= angle_q + ANGLE_W'(1);
        end
      end else if (push_o) begin
        stg_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_q.rng      <= range_mm_i;
      stg_q.scan_end <= scan_end_i;
      stg_q.valid    <= (range_mm_i >= min_valid_range_i);
      stg_q.sin_v    <= rom_w[angle_q][2*TRIG_W-1:TRIG_W];
      stg_q.cos_v    <= rom_w[angle_q][TRIG_W-1:0];
    end
  end

endmodule

### hdl/lss_back.sv
// ----------------------------------------------------------------------------
// lss_back
// Execution side: point conversion, point history, exact split test on a
// shared 17x17 multiplier, segment bookkeeping and the result register.
// ----------------------------------------------------------------------------
module lss_back #(
  parameter int unsigned TRIG_FRACTION_BITS = lss_pkg::TRIG_FRAC_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  lss_pkg::lss_item_t item_i,
  output logic               pop_o,
  input  logic [15:0]        tol_i,
  input  logic [15:0]        cap_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] begin_x_o,
  output logic signed [15:0] begin_y_o,
  output logic signed [15:0] end_x_o,
  output logic signed [15:0] end_y_o,
  output logic [15:0]        min_range_mm_o,
  output logic [8:0]         segment_index_o,
  output logic               segment_last_o
);
  import lss_pkg::*;

  localparam int unsigned AW = 2 * LIMB_W;
  localparam int unsigned TW = 4 * LIMB_W;
  localparam int unsigned LW = 6 * LIMB_W;
  localparam logic [4:0]  SPLIT_OPS = 5'd23;
  localparam logic [AW:0] RND = (AW + 1)'(1) << (TRIG_FRACTION_BITS - 1);

  function automatic logic signed [15:0] sat16(logic [AW:0] p, logic neg);
    if (neg) begin
      if (p > (AW + 1)'(32768)) return 16'sh8000;
      return 16'(-p);
    end
    if (p > (AW + 1)'(32767)) return 16'sh7fff;
    return p[15:0];
  endfunction

  function automatic logic [15:0] mag17(logic signed [16:0] v);
    return v[16] ? 16'(-v) : v[15:0];
  endfunction

  back_state_e state_q, state_d;
  logic [4:0]  step_q, step_d;

  lss_item_t   cur_q;
  logic [AW-1:0] mul_q, prod_x_q, prod_y_q;
  mul_op_t     op_q, iss;
  logic        opv_q, iss_vld;
  logic [LIMB_W-1:0] mul_a, mul_b;

  logic signed [15:0] older_x_q, older_y_q, newer_x_q, newer_y_q;
  logic signed [15:0] start_x_q, start_y_q, pnt_x_q, pnt_y_q;
  logic [1:0]  vps_q;
  logic [15:0] seg_min_q;
  logic [8:0]  seg_cnt_q;

  logic [15:0] axm_q, aym_q, bxm_q, bym_q;
  logic        sax_q, say_q, sbx_q, sby_q;
  logic signed [34:0] d_q;
  logic [AW-1:0] s1_q, s2_q, a2_q;
  logic [TW-1:0] t_q, r_q;
  logic [LW-1:0] l_q;

  logic        split_q;
  logic signed [15:0] e_sx_q, e_sy_q, e_cx_q, e_cy_q;
  logic [15:0] e_min_q;
  logic [8:0]  e_idx_q;

  logic signed [15:0] ob_x_q, ob_y_q, oe_x_q, oe_y_q;
  logic [15:0] o_min_q;
  logic [8:0]  o_idx_q;
  logic        o_last_q, out_valid_q;

  // combinational helpers
  logic [LIMB_W-1:0] sin_m, cos_m, am;
  logic [15:0]   am16;
  logic [AW:0]   rnd_x, rnd_y;
  logic signed [15:0] p_x, p_y;
  logic signed [16:0] ax_w, ay_w, bx_w, by_w;
  logic [33:0]   dm;
  logic [1:0]    k_t, k_r;
  logic [2:0]    k_l;
  logic [LW-1:0] add_v, r_ext;
  logic          s_zero, d_pos, d_neg, a_neg, split_w;
  logic [15:0]   new_min;
  logic          emit_now, out_free, out_load, finish_go, clr_scan;

  assign sin_m = cur_q.sin_v[TRIG_W-1] ? LIMB_W'(-cur_q.sin_v) : LIMB_W'(cur_q.sin_v);
  assign cos_m = cur_q.cos_v[TRIG_W-1] ? LIMB_W'(-cur_q.cos_v) : LIMB_W'(cur_q.cos_v);
  assign rnd_x = {1'b0, prod_x_q} + RND;
  assign rnd_y = {1'b0, prod_y_q} + RND;
  assign p_x   = sat16(rnd_x >> TRIG_FRACTION_BITS, cur_q.sin_v[TRIG_W-1]);
  assign p_y   = sat16(rnd_y >> TRIG_FRACTION_BITS, cur_q.cos_v[TRIG_W-1]);

  assign ax_w = {newer_x_q[15], newer_x_q} - {older_x_q[15], older_x_q};
  assign ay_w = {newer_y_q[15], newer_y_q} - {older_y_q[15], older_y_q};
  assign bx_w = {p_x[15], p_x} - {newer_x_q[15], newer_x_q};
  assign by_w = {p_y[15], p_y} - {newer_y_q[15], newer_y_q};

  assign a_neg = (tol_i > TOL_ONE);
  assign am16  = a_neg ? (tol_i - TOL_ONE) : (TOL_ONE - tol_i);
  assign am    = LIMB_W'(am16);
  assign dm    = d_q[34] ? 34'(-d_q) : 34'(d_q);

  assign k_t = 2'(step_q - 5'd7);
  assign k_r = 2'(step_q - 5'd11);
  assign k_l = 3'(step_q - 5'd15);

  // operand schedule of the shared multiplier
  always_comb begin
    iss_vld = 1'b0;
    iss.dst = AD_PX;
    iss.sh  = 3'd0;
    iss.neg = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    if (state_q == BK_CONV && step_q < 5'd2) begin
      iss_vld = 1'b1;
      mul_a   = LIMB_W'(cur_q.rng);
      if (step_q == 5'd0) begin
        mul_b   = sin_m;
      end else begin
        mul_b   = cos_m;
        iss.dst = AD_PY;
      end
    end else if (state_q == BK_SPLIT && step_q < SPLIT_OPS) begin
      iss_vld = 1'b1;
      if (step_q == 5'd0) begin
        iss.dst = AD_D; iss.neg = sax_q ^ sbx_q;
        mul_a = LIMB_W'(axm_q); mul_b = LIMB_W'(bxm_q);
      end else if (step_q == 5'd1) begin
        iss.dst = AD_D; iss.neg = say_q ^ sby_q;
        mul_a = LIMB_W'(aym_q); mul_b = LIMB_W'(bym_q);
      end else if (step_q == 5'd2) begin
        iss.dst = AD_S1; mul_a = LIMB_W'(axm_q); mul_b = LIMB_W'(axm_q);
      end else if (step_q == 5'd3) begin
        iss.dst = AD_S1; mul_a = LIMB_W'(aym_q); mul_b = LIMB_W'(aym_q);
      end else if (step_q == 5'd4) begin
        iss.dst = AD_S2; mul_a = LIMB_W'(bxm_q); mul_b = LIMB_W'(bxm_q);
      end else if (step_q == 5'd5) begin
        iss.dst = AD_S2; mul_a = LIMB_W'(bym_q); mul_b = LIMB_W'(bym_q);
      end else if (step_q == 5'd6) begin
        iss.dst = AD_A2; mul_a = am; mul_b = am;
      end else if (step_q <= 5'd10) begin
        iss.dst = AD_T;
        iss.sh  = 3'(k_t[1]) + 3'(k_t[0]);
        mul_a   = s1_q[LIMB_W*k_t[1] +: LIMB_W];
        mul_b   = s2_q[LIMB_W*k_t[0] +: LIMB_W];
      end else if (step_q <= 5'd14) begin
        iss.dst = AD_R;
        iss.sh  = 3'(k_r[1]) + 3'(k_r[0]);
        mul_a   = dm[LIMB_W*k_r[1] +: LIMB_W];
        mul_b   = dm[LIMB_W*k_r[0] +: LIMB_W];
      end else begin
        iss.dst = AD_L;
        iss.sh  = 3'(k_l[2:1]) + 3'(k_l[0]);
        mul_a   = t_q[LIMB_W*k_l[2:1] +: LIMB_W];
        mul_b   = a2_q[LIMB_W*k_l[0] +: LIMB_W];
      end
    end
  end

  assign add_v = LW'(mul_q) << (LIMB_W * op_q.sh);

  // a^2*s1*s2 against 2^28*d^2
  assign r_ext   = {{(LW - TW - TOL_SQ_SHIFT){1'b0}}, r_q, {TOL_SQ_SHIFT{1'b0}}};
  assign s_zero  = (s1_q == '0) || (s2_q == '0);
  assign d_neg   = d_q[34];
  assign d_pos   = !d_q[34] && (d_q != '0);
  assign split_w = !s_zero && (a_neg ? (d_neg && (l_q <= r_ext))
                                     : (!d_pos || (l_q >= r_ext)));
  assign new_min = (cur_q.rng < seg_min_q) ? cur_q.rng : seg_min_q;

  assign emit_now  = split_q || (cur_q.scan_end && vps_q == 2'd3);
  assign out_free  = !out_valid_q || out_ready_i;
  assign out_load  = (state_q == BK_FINISH) && emit_now && out_free;
  assign finish_go = (state_q == BK_FINISH) && (!emit_now || out_free);
  assign clr_scan  = finish_go && cur_q.scan_end;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    pop_o   = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          step_d  = '0;
          state_d = item_i.valid ? BK_CONV : BK_FINISH;
        end
      end
      BK_CONV: begin
        step_d = step_q + 5'd1;
        if (step_q == 5'd2) state_d = BK_PLACE;
      end
      BK_PLACE: begin
        step_d  = '0;
        state_d = (vps_q >= 2'd2) ? BK_SPLIT : BK_FINISH;
      end
      BK_SPLIT: begin
        step_d = step_q + 5'd1;
        if (step_q == SPLIT_OPS) state_d = BK_DECIDE;
      end
      BK_DECIDE: begin
        state_d = BK_FINISH;
      end
      BK_FINISH: begin
        if (finish_go) state_d = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      opv_q       <= 1'b0;
      vps_q       <= '0;
      seg_min_q   <= CAP_RST;
      seg_cnt_q   <= '0;
      split_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      opv_q  <= iss_vld;
      if (pop_o) split_q <= 1'b0;
      if (state_q == BK_PLACE && vps_q < 2'd2) vps_q <= vps_q + 2'd1;
      if (state_q == BK_DECIDE) begin
        vps_q   <= 2'd3;
        split_q <= split_w;
        if (split_w) begin
          seg_min_q <= cap_i;
          if (seg_cnt_q != SEG_MAX) seg_cnt_q <= seg_cnt_q + 9'd1;
        end else begin
          seg_min_q <= new_min;
        end
      end
      if (clr_scan) begin
        vps_q     <= '0;
        seg_min_q <= cap_i;
        seg_cnt_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= item_i;
    mul_q <= AW'(mul_a) * AW'(mul_b);
    op_q  <= iss;
    if (opv_q) begin
      case (op_q.dst)
        AD_PX: prod_x_q <= mul_q;
        AD_PY: prod_y_q <= mul_q;
        AD_D:  d_q <= op_q.neg ? d_q - 35'(mul_q) : d_q + 35'(mul_q);
        AD_S1: s1_q <= s1_q + mul_q;
        AD_S2: s2_q <= s2_q + mul_q;
        AD_A2: a2_q <= mul_q;
        AD_T:  t_q <= t_q + add_v[TW-1:0];
        AD_R:  r_q <= r_q + add_v[TW-1:0];
        AD_L:  l_q <= l_q + add_v;
        default: ;
      endcase
    end
    if (state_q == BK_PLACE) begin
      case (vps_q)
        2'd0: begin
          older_x_q <= p_x; older_y_q <= p_y;
          start_x_q <= p_x; start_y_q <= p_y;
        end
        2'd1: begin
          newer_x_q <= p_x; newer_y_q <= p_y;
        end
        default: begin
          pnt_x_q <= p_x; pnt_y_q <= p_y;
          axm_q <= mag17(ax_w); sax_q <= ax_w[16];
          aym_q <= mag17(ay_w); say_q <= ay_w[16];
          bxm_q <= mag17(bx_w); sbx_q <= bx_w[16];
          bym_q <= mag17(by_w); sby_q <= by_w[16];
          d_q  <= '0;
          s1_q <= '0;
          s2_q <= '0;
          t_q  <= '0;
          r_q  <= '0;
          l_q  <= '0;
        end
      endcase
    end
    if (state_q == BK_DECIDE) begin
      e_sx_q  <= start_x_q; e_sy_q <= start_y_q;
      e_cx_q  <= newer_x_q; e_cy_q <= newer_y_q;
      e_min_q <= new_min;
      e_idx_q <= seg_cnt_q;
      older_x_q <= newer_x_q; older_y_q <= newer_y_q;
      newer_x_q <= pnt_x_q;   newer_y_q <= pnt_y_q;
      if (split_w) begin
        start_x_q <= pnt_x_q; start_y_q <= pnt_y_q;
      end
    end
    if (out_load) begin
      if (split_q) begin
        ob_x_q <= e_sx_q; ob_y_q <= e_sy_q;
        oe_x_q <= e_cx_q; oe_y_q <= e_cy_q;
        o_min_q <= e_min_q; o_idx_q <= e_idx_q;
        o_last_q <= cur_q.scan_end;
      end else begin
        ob_x_q <= start_x_q; ob_y_q <= start_y_q;
        oe_x_q <= newer_x_q; oe_y_q <= newer_y_q;
        o_min_q <= seg_min_q; o_idx_q <= seg_cnt_q;
        o_last_q <= 1'b1;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign begin_x_o       = ob_x_q;
  assign begin_y_o       = ob_y_q;
  assign end_x_o         = oe_x_q;
  assign end_y_o         = oe_y_q;
  assign min_range_mm_o  = o_min_q;
  assign segment_index_o = o_idx_q;
  assign segment_last_o  = o_last_q;

  // split test only runs once two earlier points are held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_SPLIT |-> vps_q >= 2'd2)
    else $error("split test without point history");

  // multiplier results only follow conversion or split steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    opv_q |-> ($past(state_q) == BK_CONV || $past(state_q) == BK_SPLIT))
    else $error("stray multiplier result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == BK_CONV || state_q == BK_FINISH))
    else $error("bad dispatch after pop");

endmodule

### verif/lidar_scan_segmenter_core_test.sv
// ----------------------------------------------------------------------------
// lidar_scan_segmenter_core_test
// Drives range samples through valid/ready with random gaps on both sides.
// A local model rebuilds the trig table, the point conversion and the exact
// split test, and checks every emitted segment field by field. Register
// settings change between phases, the extremes among them.
// ----------------------------------------------------------------------------
module lidar_scan_segmenter_core_test;
  import lss_pkg::*;

  localparam int          STEPS     = 360;
  localparam int          FRAC      = 14;
  localparam logic [1:0]  CFG_SPARE = 2'd3;
  localparam int          LIMIT     = 600000;
  localparam int          DRAIN     = 400;

  typedef struct {
    logic [15:0] rng;
    logic        last;
    int          gap;
  } sample_t;

  typedef struct {
    logic [15:0] bx, by, ex, ey, mn;
    logic [8:0]  idx;
    logic        last;
  } segment_t;

  logic        clk_i = 1'b0, rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0, out_ready_i = 1'b0;
  logic        in_ready_o, out_valid_o;
  logic [15:0] range_mm_i = '0;
  logic        scan_end_i = 1'b0;
  logic signed [15:0] begin_x_o, begin_y_o, end_x_o, end_y_o;
  logic [15:0] min_range_mm_o;
  logic [8:0]  segment_index_o;
  logic        segment_last_o;

  lidar_scan_segmenter_core dut (.*);

  sample_t  pending_q[$];
  segment_t segments_q[$];
  int       sin_rom[STEPS], cos_rom[STEPS];
  int       errors = 0, cycles = 0, n_items = 0, n_segs = 0, n_scans = 0;
  logic     in_taken = 1'b0, out_taken = 1'b0, out_burst = 1'b0;
  int       in_wait = 0, out_wait = 0;

  // model registers and scan state
  int c_min = 100, c_tol = 3277, c_cap = 6000;
  int m_angle, m_seen, m_min, m_count;
  int m_ox, m_oy, m_nx, m_ny, m_sx, m_sy;

  function automatic int rom_round(longint q);
    if (q < 0) q = 0;
    return int'((q + (64'd1 << (29 - FRAC))) >>> (30 - FRAC));
  endfunction

  task automatic build_trig();
    longint unsigned four, quad, rem, u, u2, ts, tc;
    longint ss, cs;
    int s, c;
    for (int i = 0; i < STEPS; i++) begin
      four = 4 * i;
      quad = four / STEPS;
      rem  = four % STEPS;
      u    = (rem * HALF_PI_Q30) / STEPS;
      u2   = (u * u) >> 30;
      ts = u; tc = 64'd1 << 30;
      ss = longint'(u); cs = longint'(64'd1 << 30);
      for (int k = 1; k <= 9; k++) begin
        ts = ((ts * u2) >> 30) / ((2 * k) * (2 * k + 1));
        tc = ((tc * u2) >> 30) / ((2 * k - 1) * (2 * k));
        if (k % 2 == 1) begin
          ss -= longint'(ts); cs -= longint'(tc);
        end else begin
          ss += longint'(ts); cs += longint'(tc);
        end
      end
      s = rom_round(ss);
      c = rom_round(cs);
      case (quad % 4)
        0: begin sin_rom[i] = s;  cos_rom[i] = c;  end
        1: begin sin_rom[i] = c;  cos_rom[i] = -s; end
        2: begin sin_rom[i] = -s; cos_rom[i] = -c; end
        default: begin sin_rom[i] = -c; cos_rom[i] = s; end
      endcase
    end
  endtask

  function automatic int scale_sat(int r, int t);
    longint unsigned m, p;
    m = (t < 0) ? -t : t;
    p = (longint'(r) * m + (64'd1 << (FRAC - 1))) >> FRAC;
    if (t < 0) return (p > 32768) ? -32768 : -int'(p);
    return (p > 32767) ? 32767 : int'(p);
  endfunction

  // exact test of (1 - cos) >= tol / 2^14 on vectors older->newer->head
  function automatic bit corner_split(int x1, int y1, int x2, int y2, int x3, int y3);
    longint ax, ay, bx, by, d, a;
    logic [127:0] s1, s2, lhs, rhs, dm;
    ax = x2 - x1; ay = y2 - y1; bx = x3 - x2; by = y3 - y2;
    s1 = ax * ax + ay * ay;
    s2 = bx * bx + by * by;
    d  = ax * bx + ay * by;
    a  = 16384 - c_tol;
    dm = (d < 0) ? -d : d;
    if (s1 == 0 || s2 == 0) return 1'b0;
    lhs = 128'(a * a) * s1 * s2;
    rhs = (dm * dm) << TOL_SQ_SHIFT;
    if (a >= 0) return (d <= 0) ? 1'b1 : (lhs >= rhs);
    if (d >= 0) return 1'b0;
    return lhs <= rhs;
  endfunction

  task automatic clear_scan();
    m_angle = 0; m_seen = 0; m_count = 0; m_min = c_cap;
    m_ox = 0; m_oy = 0; m_nx = 0; m_ny = 0; m_sx = 0; m_sy = 0;
  endtask

  task automatic push_segment(int ex, int ey, logic last);
    segment_t s;
    s.bx = m_sx[15:0]; s.by = m_sy[15:0];
    s.ex = ex[15:0];   s.ey = ey[15:0];
    s.mn = m_min[15:0]; s.idx = m_count[8:0]; s.last = last;
    segments_q.push_back(s);
  endtask

  task automatic predict_segments(int r, logic last);
    int px, py, cx, cy;
    bit split;
    split = 1'b0;
    if (r >= c_min) begin
      px = scale_sat(r, sin_rom[m_angle]);
      py = scale_sat(r, cos_rom[m_angle]);
      if (m_seen == 0) begin
        m_ox = px; m_oy = py; m_sx = px; m_sy = py; m_seen = 1;
      end else if (m_seen == 1) begin
        m_nx = px; m_ny = py; m_seen = 2;
      end else begin
        cx = m_nx; cy = m_ny;
        if (r < m_min) m_min = r;
        split = corner_split(m_ox, m_oy, m_nx, m_ny, px, py);
        m_ox = m_nx; m_oy = m_ny; m_nx = px; m_ny = py; m_seen = 3;
        if (split) begin
          push_segment(cx, cy, last);
          m_sx = px; m_sy = py; m_min = c_cap;
          if (m_count < 511) m_count++;
        end
      end
    end
    m_angle = (m_angle + 1 >= STEPS) ? 0 : m_angle + 1;
    if (last) begin
      if (!split && m_seen == 3) push_segment(m_nx, m_ny, 1'b1);
      clear_scan();
      n_scans++;
    end
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // cycle limit and input-side acceptance
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t timeout with %0d segments outstanding", $time, segments_q.size());
      $display("lidar_scan_segmenter_core regression: fail");
      $finish;
    end
    if (in_valid_i && in_ready_o) begin
      predict_segments(range_mm_i, scan_end_i);
      n_items++;
      in_taken <= 1'b1;
    end
  end

  // driver: one assignment of in_valid_i per falling edge
  always @(negedge clk_i) begin
    sample_t  s;
    logic     nv;
    nv = in_valid_i;
    if (in_taken) begin
      nv = 1'b0;
      in_taken <= 1'b0;
    end
    if (!nv && rst_ni) begin
      if (in_wait > 0) in_wait--;
      else if (pending_q.size() > 0) begin
        s = pending_q.pop_front();
        if (s.gap > 0) begin
          in_wait = s.gap - 1;
          pending_q.push_front('{s.rng, s.last, 0});
        end else begin
          range_mm_i <= s.rng;
          scan_end_i <= s.last;
          nv = 1'b1;
        end
      end
    end
    in_valid_i <= nv;
  end

  // monitor
  always @(posedge clk_i) begin
    segment_t e;
    if (out_valid_o && out_ready_i) begin
      out_taken <= 1'b1;
      n_segs++;
      if (segments_q.size() == 0) begin
        $display("%0t unexpected segment begin=(%0d,%0d) end=(%0d,%0d)", $time,
                 begin_x_o, begin_y_o, end_x_o, end_y_o);
        errors++;
      end else begin
        e = segments_q.pop_front();
        if (begin_x_o !== e.bx || begin_y_o !== e.by || end_x_o !== e.ex ||
            end_y_o !== e.ey || min_range_mm_o !== e.mn ||
            segment_index_o !== e.idx || segment_last_o !== e.last) begin
          $display("%0t mismatch exp b=(%0d,%0d) e=(%0d,%0d) min=%0d idx=%0d last=%0b",
                   $time, $signed(e.bx), $signed(e.by), $signed(e.ex), $signed(e.ey),
                   e.mn, e.idx, e.last);
          $display("%0t          got b=(%0d,%0d) e=(%0d,%0d) min=%0d idx=%0d last=%0b",
                   $time, begin_x_o, begin_y_o, end_x_o, end_y_o, min_range_mm_o,
                   segment_index_o, segment_last_o);
          errors++;
        end
      end
    end
  end

  // result-side stalls
  always @(negedge clk_i) begin
    logic nr;
    nr = out_ready_i;
    if (out_taken) begin
      out_taken <= 1'b0;
      out_wait = out_burst ? 0 : $urandom_range(0, 4);
      if (out_wait > 0) nr = 1'b0;
    end else if (!nr && rst_ni) begin
      if (out_wait > 0) out_wait--;
      if (out_wait == 0) nr = 1'b1;
    end
    out_ready_i <= nr;
  end

  bit in_burst = 1'b0;

  task automatic add_sample(int r, logic last);
    pending_q.push_back('{r[15:0], last, in_burst ? 0 : $urandom_range(0, 4)});
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val[15:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MIN_RANGE: c_min = val & 16'hffff;
      CFG_TOL:       c_tol = val & 16'hffff;
      CFG_CAP:       c_cap = val & 16'hffff;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || segments_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // random scans: mostly well-formed lines and bends, some noise and invalids
  task automatic rand_scans(int count);
    int made, len, style, base, r, lo;
    made = 0;
    while (made < count) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      style = $urandom_range(0, 3);
      base = $urandom_range(c_min, 8000);
      in_burst = ($urandom_range(0, 4) == 0);
      out_burst = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < len; i++) begin
        case (style)
          0: r = $urandom_range(0, 65535);
          1: r = base + $urandom_range(0, 40) - 20;
          2: r = ($urandom_range(0, 5) == 0 && c_min > 0) ? $urandom_range(0, c_min - 1)
                                                          : base + $urandom_range(0, 200);
          default: r = (i % 4 < 2) ? base : base + $urandom_range(200, 3000);
        endcase
        if ($urandom_range(0, 7) == 0) base = $urandom_range(c_min, 20000);
        if (r < 0) r = 0;
        if (r > 65535) r = 65535;
        lo = (i == len - 1 && $urandom_range(0, 15) != 0);
        add_sample(r, lo[0]);
      end
      made += len;
    end
    add_sample($urandom_range(0, 65535), 1'b1);
  endtask

  initial begin
    build_trig();
    clear_scan();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: short scans, invalid-only scan, extremes of range
    add_sample(500, 0); add_sample(600, 1);
    add_sample(0, 1);
    add_sample(99, 0); add_sample(65535, 0); add_sample(65535, 0);
    add_sample(65535, 0); add_sample(1000, 1);
    add_sample(1000, 0); add_sample(1000, 0); add_sample(1000, 0);
    add_sample(5000, 0); add_sample(200, 0); add_sample(50, 1);
    for (int i = 0; i < 6; i++) add_sample(2000 + 3000 * (i % 2), i == 5);
    rand_scans(20);
    drain();

    // all samples valid, split on any bend, zero cap; repeated origin points
    write_reg(CFG_MIN_RANGE, 0); write_reg(CFG_TOL, 0); write_reg(CFG_CAP, 0);
    add_sample(0, 0); add_sample(0, 0); add_sample(0, 0); add_sample(300, 0);
    add_sample(300, 0); add_sample(0, 1);
    rand_scans(10);
    drain();

    // top extremes: only full-scale ranges valid, tolerance never reached
    write_reg(CFG_MIN_RANGE, 65535); write_reg(CFG_TOL, 65535);
    write_reg(CFG_CAP, 65535);
    for (int i = 0; i < 8; i++) add_sample(65535 - (i % 2), i == 7);
    rand_scans(10);
    drain();

    write_reg(CFG_MIN_RANGE, 50); write_reg(CFG_TOL, 32768); write_reg(CFG_CAP, 3000);
    rand_scans(10);
    drain();

    write_reg(CFG_TOL, 16384); write_reg(CFG_SPARE, 16'h1234);
    rand_scans(10);
    drain();

    // one long scan past the angle wrap with a split at every point
    write_reg(CFG_MIN_RANGE, 0); write_reg(CFG_TOL, 0);
    in_burst = 1'b0;
    for (int i = 0; i < 370; i++) add_sample(1000 + $urandom_range(0, 3000), i == 369);
    drain();

    write_reg(CFG_MIN_RANGE, 100); write_reg(CFG_TOL, 3277); write_reg(CFG_CAP, 6000);
    rand_scans(20);
    drain();

    $display("covered %0d samples in %0d scans, %0d segments checked, %0d cycles",
             n_items, n_scans, n_segs, cycles);
    if (errors == 0 && segments_q.size() == 0)
      $display("lidar_scan_segmenter_core regression: pass");
    else
      $display("lidar_scan_segmenter_core regression: fail");
    $finish;
  end

endmodule
